### src/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg: shared types and codes of the admission ticket ledger
// Phase, status and request kind codes, controller states and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package atl_pkg;

  // Largest value that the active and waiting limits are meant to take.
  localparam int CAP_MAX = 64;

  localparam logic [1:0] KIND_CLAIM   = 2'd0;
  localparam logic [1:0] KIND_CANCEL  = 2'd1;
  localparam logic [1:0] KIND_HOLD    = 2'd2;
  localparam logic [1:0] KIND_RELEASE = 2'd3;

  localparam logic [2:0] PH_WAITING  = 3'd0;
  localparam logic [2:0] PH_OWNED    = 3'd1;
  localparam logic [2:0] PH_HOLD     = 3'd2;
  localparam logic [2:0] PH_RELEASED = 3'd3;
  localparam logic [2:0] PH_CANCELED = 3'd4;

  localparam logic [3:0] ST_GRANTED   = 4'd0;
  localparam logic [3:0] ST_OWNED     = 4'd1;
  localparam logic [3:0] ST_QCAP      = 4'd2;
  localparam logic [3:0] ST_QFIFO     = 4'd3;
  localparam logic [3:0] ST_QFULL     = 4'd4;
  localparam logic [3:0] ST_EXHAUSTED = 4'd5;
  localparam logic [3:0] ST_HFULL     = 4'd6;
  localparam logic [3:0] ST_CANCELED  = 4'd7;
  localparam logic [3:0] ST_HOLD      = 4'd8;
  localparam logic [3:0] ST_RELEASED  = 4'd9;
  localparam logic [3:0] ST_NOTFOUND  = 4'd10;
  localparam logic [3:0] ST_NOPROOF   = 4'd11;
  localparam logic [3:0] ST_NESTED    = 4'd12;

  localparam logic [1:0] REG_ACTIVE_CAP   = 2'd0;
  localparam logic [1:0] REG_WAIT_LIMIT   = 2'd1;
  localparam logic [1:0] REG_GRANT_BUDGET = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_FIFO_RD,
    S_FIFO_CHK,
    S_FINISH,
    S_OUT
  } ctl_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture request
    logic scan_clr;   // clear scan pointer
    logic scan_rd;    // issue table read at scan pointer
    logic scan_step;  // compare read data, advance pointer
    logic decide;     // apply lookup result and phase change
    logic fifo_step;  // compare phase for oldest waiting search
    logic finish;     // final grant decision, build result
  } atl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic nested_refuse; // nested claim, answer directly
    logic scan_done;     // pointer reached entry count or match found
    logic fifo_needed;   // waiting entry eligible for the oldest search
    logic fifo_done;     // search reached the entry or found an older waiter
  } atl_sts_t;

endpackage

### src/atl_if.sv
// ----------------------------------------------------------------------------
// atl_req_if / atl_rsp_if: request and result channels
// Valid/ready channels with source and sink modports.
// ----------------------------------------------------------------------------
interface atl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] run_tag;
  logic [31:0] task_id;
  logic [31:0] attempt_no;
  logic        proof;
  logic        nested;
  modport source (output valid, kind, run_tag, task_id, attempt_no, proof, nested,
                  input ready);
  modport sink (input valid, kind, run_tag, task_id, attempt_no, proof, nested,
                output ready);
endinterface

interface atl_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [6:0]  ticket;
  logic [31:0] claims_used;
  logic [6:0]  active_count;
  logic [6:0]  queued_count;
  modport source (output valid, status, ticket, claims_used, active_count,
                  queued_count, input ready);
  modport sink (input valid, status, ticket, claims_used, active_count,
                queued_count, output ready);
endinterface

### src/atl_ram.sv
// ----------------------------------------------------------------------------
// atl_ram: generic simple dual-port RAM
// One write and one read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module atl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/atl_ctrl.sv
// ----------------------------------------------------------------------------
// atl_ctrl: request sequencer
// Steps each request through lookup scan, decision, oldest-waiter scan
// and result delivery; a nested claim goes straight to result delivery.
// ----------------------------------------------------------------------------
module atl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  atl_pkg::atl_sts_t sts,
  output atl_pkg::atl_cmd_t cmd
);
  atl_pkg::ctl_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      atl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = atl_pkg::S_SCAN_RD;
        end
      end
      atl_pkg::S_SCAN_RD: begin
        if (sts.nested_refuse) begin
          cmd.finish = 1'b1;
          state_nxt  = atl_pkg::S_OUT;
        end else if (sts.scan_done) begin
          state_nxt = atl_pkg::S_DECIDE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = atl_pkg::S_SCAN_CHK;
        end
      end
      atl_pkg::S_SCAN_CHK: begin
        cmd.scan_step = 1'b1;
        state_nxt     = atl_pkg::S_SCAN_RD;
      end
      atl_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = atl_pkg::S_FIFO_RD;
      end
      atl_pkg::S_FIFO_RD: begin
        if (!sts.fifo_needed || sts.fifo_done) begin
          state_nxt = atl_pkg::S_FINISH;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = atl_pkg::S_FIFO_CHK;
        end
      end
      atl_pkg::S_FIFO_CHK: begin
        cmd.fifo_step = 1'b1;
        state_nxt     = atl_pkg::S_FIFO_RD;
      end
      atl_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = atl_pkg::S_OUT;
      end
      atl_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = atl_pkg::S_IDLE;
        end
      end
      default: state_nxt = atl_pkg::S_IDLE;
    endcase
  end

  // A result is shown only after the request was taken and before the next.
  a_rdy_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_load_go: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == atl_pkg::S_SCAN_RD) else $error("load did not start scan");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

### src/atl_dp.sv
// ----------------------------------------------------------------------------
// atl_dp: ledger datapath
// Request registers, history table RAMs, counters, scan pointers and
// the result register.
// ----------------------------------------------------------------------------
module atl_dp #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  atl_pkg::atl_cmd_t cmd,
  output atl_pkg::atl_sts_t sts,
  input  logic [1:0]        in_kind,
  input  logic [31:0]       in_run_tag,
  input  logic [31:0]       in_task_id,
  input  logic [31:0]       in_attempt_no,
  input  logic              in_proof,
  input  logic              in_nested,
  input  logic [6:0]        active_cap,
  input  logic [6:0]        wait_limit,
  input  logic [31:0]       grant_budget,
  output logic [3:0]        out_status,
  output logic [6:0]        out_ticket,
  output logic [31:0]       out_claims_used,
  output logic [6:0]        out_active_count,
  output logic [6:0]        out_queued_count
);
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  logic [1:0]  kind_r;
  logic [31:0] run_r, task_r, att_r;
  logic        proof_r, nested_r;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] grants_r, grants_nxt;
  logic [6:0]  active_r, active_nxt;
  logic [6:0]  waiting_r, waiting_nxt;
  logic        found_r, found_nxt;
  logic        need_r, need_nxt;
  logic        older_r, older_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic        early_r, early_nxt;
  logic [3:0]  est_r, est_nxt;
  logic [3:0]  st_r, st_nxt;
  logic [6:0]  tk_r, tk_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [2:0]    wphase;
  logic [31:0]   rd_run, rd_task, rd_att;
  logic [2:0]    rd_ph;

  // History table: identity fields and phase.
  atl_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_run (
    .clk, .we(we && cmd.decide), .waddr, .wdata(run_r), .raddr, .rdata(rd_run));
  atl_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_task (
    .clk, .we(we && cmd.decide), .waddr, .wdata(task_r), .raddr, .rdata(rd_task));
  atl_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_att (
    .clk, .we(we && cmd.decide), .waddr, .wdata(att_r), .raddr, .rdata(rd_att));
  atl_ram #(.WIDTH(3), .DEPTH(HISTORY_DEPTH)) u_ph (
    .clk, .we, .waddr, .wdata(wphase), .raddr, .rdata(rd_ph));

  // Writes go to the entry being worked, which is the new one on an append.
  assign raddr = ptr_r[AW-1:0];
  assign waddr = idx_nxt[AW-1:0];

  // Status toward the controller.
  always_comb begin
    sts.nested_refuse = (kind_r == atl_pkg::KIND_CLAIM) && nested_r;
    sts.scan_done     = found_r || (ptr_r >= count_r);
    sts.fifo_needed   = need_r;
    sts.fifo_done     = older_r || (ptr_r >= idx_r);
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      run_r    <= in_run_tag;
      task_r   <= in_task_id;
      att_r    <= in_attempt_no;
      proof_r  <= in_proof;
      nested_r <= in_nested;
    end
  end

  // Lookup, decision and grant.
  always_comb begin
    logic       is_claim, is_cancel;
    logic [2:0] ph;
    ptr_nxt = ptr_r; idx_nxt = idx_r; count_nxt = count_r;
    grants_nxt = grants_r; active_nxt = active_r; waiting_nxt = waiting_r;
    found_nxt = found_r; need_nxt = need_r; older_nxt = older_r;
    ph_nxt = ph_r; early_nxt = early_r; est_nxt = est_r;
    st_nxt = st_r; tk_nxt = tk_r;
    we = 1'b0; wphase = ph_r;
    is_claim  = kind_r == atl_pkg::KIND_CLAIM;
    is_cancel = kind_r == atl_pkg::KIND_CANCEL;
    ph = rd_ph;

    if (cmd.scan_clr) begin
      ptr_nxt = '0;
      found_nxt = 1'b0;
    end
    if (cmd.scan_step) begin
      if (rd_run == run_r && rd_task == task_r && rd_att == att_r) begin
        found_nxt = 1'b1;
        idx_nxt = ptr_r;
        ph_nxt = rd_ph;
      end else begin
        ptr_nxt = ptr_r + 1'b1;
      end
    end
    if (cmd.decide) begin
      early_nxt = 1'b0;
      need_nxt = 1'b0;
      older_nxt = 1'b0;
      ptr_nxt = '0;
      ph = ph_r;
      if (!found_r) begin
        if (!is_claim && !is_cancel) begin
          early_nxt = 1'b1; est_nxt = atl_pkg::ST_NOTFOUND;
        end else if (is_claim && grants_r >= grant_budget) begin
          early_nxt = 1'b1; est_nxt = atl_pkg::ST_EXHAUSTED;
        end else if (count_r >= CW'(HISTORY_DEPTH)) begin
          early_nxt = 1'b1; est_nxt = atl_pkg::ST_HFULL;
        end else if (is_claim && waiting_r >= wait_limit) begin
          early_nxt = 1'b1; est_nxt = atl_pkg::ST_QFULL;
        end else begin
          we = 1'b1;
          idx_nxt = count_r;
          ph = is_cancel ? atl_pkg::PH_CANCELED : atl_pkg::PH_WAITING;
          if (!is_cancel) waiting_nxt = waiting_r + 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      if (!early_nxt) begin
        if (is_cancel && ph == atl_pkg::PH_WAITING) begin
          ph = atl_pkg::PH_CANCELED;
          waiting_nxt = waiting_nxt - 1'b1;
          we = 1'b1;
        end else if ((is_cancel || kind_r == atl_pkg::KIND_HOLD) &&
                     ph == atl_pkg::PH_OWNED) begin
          ph = atl_pkg::PH_HOLD;
          we = 1'b1;
        end else if (kind_r == atl_pkg::KIND_RELEASE &&
                     (ph == atl_pkg::PH_OWNED || ph == atl_pkg::PH_HOLD)) begin
          if (!proof_r) begin
            early_nxt = 1'b1; est_nxt = atl_pkg::ST_NOPROOF;
          end else begin
            ph = atl_pkg::PH_RELEASED;
            active_nxt = active_r - 1'b1;
            we = 1'b1;
          end
        end
        if (!early_nxt && ph == atl_pkg::PH_WAITING && is_claim &&
            grants_r < grant_budget && active_nxt < active_cap) begin
          need_nxt = 1'b1;
        end
      end
      ph_nxt = ph;
      wphase = ph;
    end
    if (cmd.fifo_step) begin
      if (rd_ph == atl_pkg::PH_WAITING) older_nxt = 1'b1;
      else ptr_nxt = ptr_r + 1'b1;
    end
    if (cmd.finish) begin
      tk_nxt = 7'(idx_r + 1'b1);
      if (sts.nested_refuse) begin
        st_nxt = atl_pkg::ST_NESTED; tk_nxt = '0;
      end else if (early_r) begin
        st_nxt = est_r;
        if (est_r != atl_pkg::ST_NOPROOF) tk_nxt = '0;
      end else begin
        case (ph_r)
          atl_pkg::PH_OWNED:    st_nxt = atl_pkg::ST_OWNED;
          atl_pkg::PH_HOLD:     st_nxt = atl_pkg::ST_HOLD;
          atl_pkg::PH_RELEASED: st_nxt = atl_pkg::ST_RELEASED;
          atl_pkg::PH_CANCELED: st_nxt = atl_pkg::ST_CANCELED;
          default: begin
            if (grants_r >= grant_budget) st_nxt = atl_pkg::ST_EXHAUSTED;
            else if (active_r >= active_cap) st_nxt = atl_pkg::ST_QCAP;
            else if (need_r && !older_r) begin
              st_nxt = atl_pkg::ST_GRANTED;
              we = 1'b1;
              wphase = atl_pkg::PH_OWNED;
              waiting_nxt = waiting_r - 1'b1;
              active_nxt = active_r + 1'b1;
              grants_nxt = grants_r + 1'b1;
            end else st_nxt = atl_pkg::ST_QFIFO;
          end
        endcase
      end
    end
  end

  // Counters and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; grants_r <= '0; active_r <= '0; waiting_r <= '0;
      found_r <= 1'b0; need_r <= 1'b0; older_r <= 1'b0; early_r <= 1'b0;
      ptr_r <= '0; idx_r <= '0;
    end else begin
      count_r <= count_nxt; grants_r <= grants_nxt;
      active_r <= active_nxt; waiting_r <= waiting_nxt;
      found_r <= found_nxt; need_r <= need_nxt; older_r <= older_nxt;
      early_r <= early_nxt; ptr_r <= ptr_nxt; idx_r <= idx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ph_r <= ph_nxt; est_r <= est_nxt; st_r <= st_nxt; tk_r <= tk_nxt;
  end

  assign out_status       = st_r;
  assign out_ticket       = tk_r;
  assign out_claims_used  = grants_r;
  assign out_active_count = active_r;
  assign out_queued_count = waiting_r;

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(HISTORY_DEPTH)) else $error("entry count overflow");
  a_grant_inc: assert property (@(posedge clk) disable iff (!rst_n)
    grants_r != $past(grants_r) |-> $past(cmd.finish)) else $error("stray grant");
  a_wait_le: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, waiting_r} + {1'b0, active_r} <= 8'(count_r)) else $error("counts exceed table");
  a_active_max: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= 7'(atl_pkg::CAP_MAX)) else $error("active count above limit");
endmodule

### src/admission_ticket_ledger_unit.sv
// ----------------------------------------------------------------------------
// admission_ticket_ledger_unit: admission controller with history table
// Top level joining config registers, sequencer and ledger datapath.
// ----------------------------------------------------------------------------
// Usage: a request (claim, cancel, hold, release with its identity) enters on
// the in_ channel; exactly one result (status, ticket, counters) leaves on
// the out_ channel. The active cap, the waiting limit and the lifetime grant
// budget sit at byte addresses 0, 4 and 8 of the APB-style cfg_ port; the
// user must write them only while no request is in flight (not enforced).
// A request passes through an identity lookup scan over the history table,
// reading and comparing one entry at a time up to a match or the entry count,
// then a decision and an oldest-waiter scan, which runs only for a claim that
// may be granted, and then the result. A nested claim skips both scans. One
// request is worked at once: the next request is taken in the cycle after
// the result is accepted.
// Reset clears the counters and the entry count; table contents are not
// cleared since only entries below the count are read. While the receiver
// stalls the result is held and no new request is taken.
// ----------------------------------------------------------------------------
module admission_ticket_ledger_unit #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  atl_req_if.sink     in_ch,
  atl_rsp_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  atl_pkg::atl_cmd_t cmd;
  atl_pkg::atl_sts_t sts;
  logic [6:0]  active_cap_r, wait_limit_r;
  logic [31:0] grant_budget_r;
  logic [1:0]  reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel = cfg_paddr[3:2];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_cap_r <= 7'd1; wait_limit_r <= 7'd1; grant_budget_r <= 32'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_sel)
        atl_pkg::REG_ACTIVE_CAP:   active_cap_r   <= cfg_pwdata[6:0];
        atl_pkg::REG_WAIT_LIMIT:   wait_limit_r   <= cfg_pwdata[6:0];
        atl_pkg::REG_GRANT_BUDGET: grant_budget_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_sel)
      atl_pkg::REG_ACTIVE_CAP:   cfg_prdata = {25'd0, active_cap_r};
      atl_pkg::REG_WAIT_LIMIT:   cfg_prdata = {25'd0, wait_limit_r};
      atl_pkg::REG_GRANT_BUDGET: cfg_prdata = grant_budget_r;
      default:                   cfg_prdata = '0;
    endcase
  end

  atl_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts, .cmd);

  atl_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_kind(in_ch.kind), .in_run_tag(in_ch.run_tag), .in_task_id(in_ch.task_id),
    .in_attempt_no(in_ch.attempt_no), .in_proof(in_ch.proof),
    .in_nested(in_ch.nested),
    .active_cap(active_cap_r), .wait_limit(wait_limit_r),
    .grant_budget(grant_budget_r),
    .out_status(out_ch.status), .out_ticket(out_ch.ticket),
    .out_claims_used(out_ch.claims_used), .out_active_count(out_ch.active_count),
    .out_queued_count(out_ch.queued_count));
endmodule
